// ===== sv/uvs_pkg.sv =====
// shared types, constants and arithmetic helpers of the uv sphere mesh generator
package uvs_pkg;

    // limits of the mesh grid
    localparam int MAX_STACKS   = 256;
    localparam int MAX_SECTORS  = 256;
    localparam int CNT_CMP_W    = 11;

    // angle unit depth
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_PER_STAGE = 2;
    localparam int CORDIC_STAGES    = (CORDIC_STEPS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;
    localparam int PHASE_BITS       = 32;
    localparam int DIV_PER_STAGE    = 4;
    localparam int DIV_STAGES       = PHASE_BITS / DIV_PER_STAGE;
    localparam int ANGLE_LAT        = DIV_STAGES + 1 + CORDIC_STAGES + 1;

    // cordic constants, Q2.30 gain and arctangents in turns of 2^32
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
    localparam int ATAN_COUNT = 24;
    localparam logic signed [31:0] ATAN_TURNS [ATAN_COUNT] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // configuration register indexes
    localparam logic [2:0] CFG_RADIUS   = 3'd0;
    localparam logic [2:0] CFG_SECTORS  = 3'd1;
    localparam logic [2:0] CFG_STACKS   = 3'd2;
    localparam logic [2:0] CFG_CENTER_X = 3'd3;
    localparam logic [2:0] CFG_CENTER_Y = 3'd4;
    localparam logic [2:0] CFG_CENTER_Z = 3'd5;

    // configuration reset values
    localparam logic [22:0] RADIUS_RST  = 23'd4096;
    localparam logic [8:0]  SECTORS_RST = 9'd36;
    localparam logic [8:0]  STACKS_RST  = 9'd18;

    // request kinds
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic       kind;
        logic [8:0] stack_index;
        logic [8:0] sector_index;
    } req_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [16:0]        corner_a;
        logic [16:0]        corner_b;
        logic [16:0]        corner_c;
        logic               last;
    } rsp_t;

    // angle request: remainder of the grid index, divisor, wrap flag, latitude flag
    typedef struct packed {
        logic [8:0] rem;
        logic [8:0] dvs;
        logic       full;
        logic       is_u;
    } ang_in_t;

    typedef struct packed {
        logic [8:0]  rem;
        logic [8:0]  dvs;
        logic        full;
        logic        is_u;
        logic [31:0] quo;
    } div_t;

    typedef struct packed {
        quad_t              quad;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cd_t;

    // result flags that travel beside the datapath
    typedef struct packed {
        logic        vtx;
        logic        tri_a;
        logic        tri_b;
        logic [16:0] k1;
        logic [16:0] k2;
    } side_t;

    // a few quotient bits of the fractional long division
    function automatic div_t div_step(input div_t d);
        div_t       r;
        logic [9:0] t;
        logic       qb;
        r = d;
        for (int b = 0; b < DIV_PER_STAGE; b++)
        begin
            t  = {r.rem, 1'b0};
            qb = (t >= {1'b0, r.dvs});
            if (qb)
            begin
                t = t - {1'b0, r.dvs};
            end
            r.rem = t[8:0];
            r.quo = {r.quo[30:0], qb};
        end
        return r;
    endfunction

    // phase to quadrant and cordic start vector
    function automatic cd_t phase_start(input div_t d);
        cd_t         c;
        logic [32:0] qf;
        logic [31:0] p;
        logic [31:0] p2;
        qf = {d.full, d.quo};
        if (d.is_u)
        begin
            p = 32'h4000_0000 - qf[32:1];
        end
        else
        begin
            p = d.quo;
        end
        p2     = p + 32'h2000_0000;
        c.quad = quad_t'(p2[31:30]);
        c.z    = $signed({2'b00, p2[29:0]}) - 32'sh2000_0000;
        c.x    = GAIN_Q30;
        c.y    = '0;
        return c;
    endfunction

    // cordic rotations of one stage
    function automatic cd_t cordic_steps(input cd_t c, input int first);
        cd_t                r;
        int                 k;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        r = c;
        x = c.x;
        y = c.y;
        z = c.z;
        for (int b = 0; b < CORDIC_PER_STAGE; b++)
        begin
            k = first + b;
            if (k < CORDIC_STEPS && k < ATAN_COUNT)
            begin
                dx = y >>> k;
                dy = x >>> k;
                if (!z[31])
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_TURNS[k[4:0]];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_TURNS[k[4:0]];
                end
            end
        end
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    // saturate a position sum to Q12.12
    function automatic logic signed [23:0] sat_pos(input logic signed [28:0] v);
        logic signed [23:0] r;
        if (v > 29'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -29'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    // clamp a normal component to plus or minus one in Q1.14
    function automatic logic signed [15:0] clamp_norm(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd16384)
        begin
            r = 16'sd16384;
        end
        else if (v < -18'sd16384)
        begin
            r = -16'sd16384;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/uvs_angle.sv =====
// pipelined angle unit: grid index to phase by long division, then cordic sine and cosine
module uvs_angle
(
    input  logic                  clk,
    input  logic                  en,
    input  uvs_pkg::ang_in_t      ang,
    output logic signed [31:0]    cos_val,
    output logic signed [31:0]    sin_val
);

    uvs_pkg::div_t div_in  [uvs_pkg::DIV_STAGES];
    uvs_pkg::div_t div_reg [uvs_pkg::DIV_STAGES];
    uvs_pkg::cd_t  ph_reg;
    uvs_pkg::cd_t  cd_in   [uvs_pkg::CORDIC_STAGES];
    uvs_pkg::cd_t  cd_reg  [uvs_pkg::CORDIC_STAGES];
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_next;
    uvs_pkg::cd_t  cd_last;

    // fractional long division stages
    genvar g;
    generate
        for (g = 0; g < uvs_pkg::DIV_STAGES; g++)
        begin : g_div
            if (g == 0)
            begin : g_first
                assign div_in[g] = '{rem: ang.rem, dvs: ang.dvs, full: ang.full,
                                     is_u: ang.is_u, quo: '0};
            end
            else
            begin : g_rest
                assign div_in[g] = div_reg[g-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    div_reg[g] <= uvs_pkg::div_step(div_in[g]);
                end
            end
        end
    endgenerate

    // phase and quadrant split
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg <= uvs_pkg::phase_start(div_reg[uvs_pkg::DIV_STAGES-1]);
        end
    end

    // cordic rotation stages
    generate
        for (g = 0; g < uvs_pkg::CORDIC_STAGES; g++)
        begin : g_cd
            if (g == 0)
            begin : g_first
                assign cd_in[g] = ph_reg;
            end
            else
            begin : g_rest
                assign cd_in[g] = cd_reg[g-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cd_reg[g] <= uvs_pkg::cordic_steps(cd_in[g], g * uvs_pkg::CORDIC_PER_STAGE);
                end
            end
        end
    endgenerate

    // quadrant applied exactly
    assign cd_last = cd_reg[uvs_pkg::CORDIC_STAGES-1];

    always_comb
    begin
        unique case (cd_last.quad)
            uvs_pkg::QUAD_0:
            begin
                cos_next = cd_last.x;
                sin_next = cd_last.y;
            end
            uvs_pkg::QUAD_1:
            begin
                cos_next = -cd_last.y;
                sin_next = cd_last.x;
            end
            uvs_pkg::QUAD_2:
            begin
                cos_next = -cd_last.x;
                sin_next = -cd_last.y;
            end
            default:
            begin
                cos_next = cd_last.y;
                sin_next = -cd_last.x;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// ===== sv/uv_sphere_mesh_generator.sv =====
// top level of the uv sphere mesh generator: decode, angle units, scaling and result buffer
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req (kind, stack and sector index)
//  rsp     | out       | rsp_valid / rsp_ready  | rsp (position, normal, corners, last)
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one request enters per cycle while the result buffer does not stall the pipeline
// a result passes decode, the angle units (8 division and 8 cordic stages), scaling and buffer
// a request with two triangles holds the pipeline while its second result waits in the buffer
// when the result buffer cannot drain, every stage freezes together and nothing is lost
// reset restores the register defaults and empties the pipeline; cfg is always ready
module uv_sphere_mesh_generator
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  uvs_pkg::req_t       req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output uvs_pkg::rsp_t       rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    // configuration registers
    logic [22:0]        radius_reg;
    logic [8:0]         sectors_reg;
    logic [8:0]         stacks_reg;
    logic signed [23:0] cx_reg;
    logic signed [23:0] cy_reg;
    logic signed [23:0] cz_reg;

    logic pipe_en;

    // decode stage
    uvs_pkg::side_t   s0_side_next;
    uvs_pkg::side_t   s0_side_reg;
    uvs_pkg::ang_in_t s0_u_next;
    uvs_pkg::ang_in_t s0_v_next;
    uvs_pkg::ang_in_t s0_u_reg;
    uvs_pkg::ang_in_t s0_v_reg;

    logic        cnt_bad;
    logic        accept;
    logic [18:0] k1_full;
    logic [16:0] k1;
    logic [16:0] k2;

    // angle unit outputs
    logic signed [31:0] cu;
    logic signed [31:0] su;
    logic signed [31:0] cv;
    logic signed [31:0] sv;

    uvs_pkg::side_t side_reg [uvs_pkg::ANGLE_LAT];

    // scaling stages
    uvs_pkg::side_t     m1_side_reg;
    logic signed [55:0] m1_rcu_reg;
    logic signed [55:0] m1_rsu_reg;
    logic signed [63:0] m1_cc_reg;
    logic signed [63:0] m1_cs_reg;
    logic signed [31:0] m1_cv_reg;
    logic signed [31:0] m1_sv_reg;
    logic signed [31:0] m1_su_reg;

    uvs_pkg::side_t     m2_side_reg;
    logic signed [57:0] m2_px_reg;
    logic signed [57:0] m2_py_reg;
    logic signed [25:0] m2_z_reg;
    logic signed [15:0] m2_nx_reg;
    logic signed [15:0] m2_ny_reg;
    logic signed [15:0] m2_nz_reg;
    logic signed [55:0] rcu_rnd;
    logic signed [55:0] rsu_rnd;
    logic signed [25:0] xy_val;
    logic signed [25:0] z_val;
    logic signed [63:0] cc_rnd;
    logic signed [63:0] cs_rnd;
    logic signed [31:0] su_rnd;

    uvs_pkg::side_t     m3_side_reg;
    logic signed [23:0] m3_px_reg;
    logic signed [23:0] m3_py_reg;
    logic signed [23:0] m3_pz_reg;
    logic signed [15:0] m3_nx_reg;
    logic signed [15:0] m3_ny_reg;
    logic signed [15:0] m3_nz_reg;
    logic signed [57:0] px_rnd;
    logic signed [57:0] py_rnd;
    logic signed [27:0] x_val;
    logic signed [27:0] y_val;

    // result buffer
    uvs_pkg::rsp_t first_item;
    uvs_pkg::rsp_t second_item;
    logic          emit_first;
    logic          emit_second;
    uvs_pkg::rsp_t cur_reg;
    uvs_pkg::rsp_t nxt_reg;
    logic          cur_valid_reg;
    logic          nxt_valid_reg;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= uvs_pkg::RADIUS_RST;
            sectors_reg <= uvs_pkg::SECTORS_RST;
            stacks_reg  <= uvs_pkg::STACKS_RST;
            cx_reg      <= '0;
            cy_reg      <= '0;
            cz_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                uvs_pkg::CFG_RADIUS:   radius_reg  <= cfg_data[22:0];
                uvs_pkg::CFG_SECTORS:  sectors_reg <= cfg_data[8:0];
                uvs_pkg::CFG_STACKS:   stacks_reg  <= cfg_data[8:0];
                uvs_pkg::CFG_CENTER_X: cx_reg      <= $signed(cfg_data);
                uvs_pkg::CFG_CENTER_Y: cy_reg      <= $signed(cfg_data);
                uvs_pkg::CFG_CENTER_Z: cz_reg      <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the result buffer can take a new request's results
    assign pipe_en   = !cur_valid_reg || (rsp_ready && !nxt_valid_reg);
    assign req_ready = pipe_en;
    assign accept    = req_valid && req_ready;

    // request decode
    always_comb
    begin
        cnt_bad = (stacks_reg == '0) || (sectors_reg == '0)
               || ({2'b00, stacks_reg} > uvs_pkg::CNT_CMP_W'(uvs_pkg::MAX_STACKS))
               || ({2'b00, sectors_reg} > uvs_pkg::CNT_CMP_W'(uvs_pkg::MAX_SECTORS));

        k1_full = 19'(req.stack_index) * 19'({1'b0, sectors_reg} + 10'd1)
                + 19'(req.sector_index);
        k1      = k1_full[16:0];
        k2      = k1 + 17'(sectors_reg) + 17'd1;

        s0_side_next.vtx   = accept && !cnt_bad && (req.kind == uvs_pkg::KIND_VERTEX)
                          && (req.stack_index <= stacks_reg)
                          && (req.sector_index <= sectors_reg);
        s0_side_next.tri_a = accept && !cnt_bad && (req.kind == uvs_pkg::KIND_TRIANGLE)
                          && (req.stack_index < stacks_reg)
                          && (req.sector_index < sectors_reg)
                          && (req.stack_index != '0);
        s0_side_next.tri_b = accept && !cnt_bad && (req.kind == uvs_pkg::KIND_TRIANGLE)
                          && (req.stack_index < stacks_reg)
                          && (req.sector_index < sectors_reg)
                          && (req.stack_index != stacks_reg - 9'd1);
        s0_side_next.k1    = k1;
        s0_side_next.k2    = k2;

        s0_u_next.full = (req.stack_index == stacks_reg);
        s0_u_next.rem  = s0_u_next.full ? '0 : req.stack_index;
        s0_u_next.dvs  = stacks_reg;
        s0_u_next.is_u = 1'b1;

        s0_v_next.full = 1'b0;
        s0_v_next.rem  = (req.sector_index == sectors_reg) ? '0 : req.sector_index;
        s0_v_next.dvs  = sectors_reg;
        s0_v_next.is_u = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_side_reg <= '0;
        end
        else if (pipe_en)
        begin
            s0_side_reg <= s0_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s0_u_reg <= s0_u_next;
            s0_v_reg <= s0_v_next;
        end
    end

    // latitude and longitude angle units
    uvs_angle u_angle_u
    (
        .clk     (clk),
        .en      (pipe_en),
        .ang     (s0_u_reg),
        .cos_val (cu),
        .sin_val (su)
    );

    uvs_angle u_angle_v
    (
        .clk     (clk),
        .en      (pipe_en),
        .ang     (s0_v_reg),
        .cos_val (cv),
        .sin_val (sv)
    );

    // result flags follow the angle units
    genvar g;
    generate
        for (g = 0; g < uvs_pkg::ANGLE_LAT; g++)
        begin : g_side
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[g] <= '0;
                end
                else if (pipe_en)
                begin
                    if (g == 0)
                    begin
                        side_reg[g] <= s0_side_reg;
                    end
                    else
                    begin
                        side_reg[g] <= side_reg[(g == 0) ? 0 : g-1];
                    end
                end
            end
        end
    endgenerate

    // first products: radius scaling and normal products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_side_reg <= '0;
            m2_side_reg <= '0;
            m3_side_reg <= '0;
        end
        else if (pipe_en)
        begin
            m1_side_reg <= side_reg[uvs_pkg::ANGLE_LAT-1];
            m2_side_reg <= m1_side_reg;
            m3_side_reg <= m2_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m1_rcu_reg <= $signed({1'b0, radius_reg}) * cu;
            m1_rsu_reg <= $signed({1'b0, radius_reg}) * su;
            m1_cc_reg  <= cu * cv;
            m1_cs_reg  <= cu * sv;
            m1_cv_reg  <= cv;
            m1_sv_reg  <= sv;
            m1_su_reg  <= su;
        end
    end

    // rounding of the radius products and second products
    always_comb
    begin
        rcu_rnd = (m1_rcu_reg + 56'sd536870912) >>> 30;
        rsu_rnd = (m1_rsu_reg + 56'sd536870912) >>> 30;
        xy_val  = rcu_rnd[25:0];
        z_val   = rsu_rnd[25:0];
        cc_rnd  = (m1_cc_reg + 64'sh0000_2000_0000_0000) >>> 46;
        cs_rnd  = (m1_cs_reg + 64'sh0000_2000_0000_0000) >>> 46;
        su_rnd  = (m1_su_reg + 32'sd32768) >>> 16;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m2_px_reg <= xy_val * m1_cv_reg;
            m2_py_reg <= xy_val * m1_sv_reg;
            m2_z_reg  <= z_val;
            m2_nx_reg <= uvs_pkg::clamp_norm(cc_rnd[17:0]);
            m2_ny_reg <= uvs_pkg::clamp_norm(cs_rnd[17:0]);
            m2_nz_reg <= uvs_pkg::clamp_norm(su_rnd[17:0]);
        end
    end

    // final rounding, centre offset and saturation
    always_comb
    begin
        px_rnd = (m2_px_reg + 58'sd536870912) >>> 30;
        py_rnd = (m2_py_reg + 58'sd536870912) >>> 30;
        x_val  = px_rnd[27:0];
        y_val  = py_rnd[27:0];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m3_px_reg <= uvs_pkg::sat_pos(29'(x_val) + 29'(cx_reg));
            m3_py_reg <= uvs_pkg::sat_pos(29'(y_val) + 29'(cy_reg));
            m3_pz_reg <= uvs_pkg::sat_pos(29'(m2_z_reg) + 29'(cz_reg));
            m3_nx_reg <= m2_nx_reg;
            m3_ny_reg <= m2_ny_reg;
            m3_nz_reg <= m2_nz_reg;
        end
    end

    // result assembly
    always_comb
    begin
        first_item  = '0;
        second_item = '0;
        if (m3_side_reg.vtx)
        begin
            first_item.pos_x    = m3_px_reg;
            first_item.pos_y    = m3_py_reg;
            first_item.pos_z    = m3_pz_reg;
            first_item.normal_x = m3_nx_reg;
            first_item.normal_y = m3_ny_reg;
            first_item.normal_z = m3_nz_reg;
            first_item.last     = 1'b1;
        end
        else if (m3_side_reg.tri_a)
        begin
            first_item.corner_a = m3_side_reg.k1;
            first_item.corner_b = m3_side_reg.k2;
            first_item.corner_c = m3_side_reg.k1 + 17'd1;
            first_item.last     = !m3_side_reg.tri_b;
        end
        else
        begin
            first_item.corner_a = m3_side_reg.k1 + 17'd1;
            first_item.corner_b = m3_side_reg.k2;
            first_item.corner_c = m3_side_reg.k2 + 17'd1;
            first_item.last     = 1'b1;
        end
        second_item.corner_a = m3_side_reg.k1 + 17'd1;
        second_item.corner_b = m3_side_reg.k2;
        second_item.corner_c = m3_side_reg.k2 + 17'd1;
        second_item.last     = 1'b1;

        emit_first  = m3_side_reg.vtx || m3_side_reg.tri_a || m3_side_reg.tri_b;
        emit_second = m3_side_reg.tri_a && m3_side_reg.tri_b;
    end

    // two-entry result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            nxt_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            cur_valid_reg <= emit_first;
            nxt_valid_reg <= emit_second;
        end
        else if (rsp_ready && cur_valid_reg)
        begin
            cur_valid_reg <= nxt_valid_reg;
            nxt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            cur_reg <= first_item;
            nxt_reg <= second_item;
        end
        else if (rsp_ready && cur_valid_reg)
        begin
            cur_reg <= nxt_reg;
        end
    end

    assign rsp_valid = cur_valid_reg;
    assign rsp       = cur_reg;

    // second buffer entry only behind a waiting first
    assert property (@(posedge clk) disable iff (!rst_n)
        nxt_valid_reg |-> cur_valid_reg)
        else $error("second result buffered without a first");

    // a buffered second result means the first is not the last of its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        nxt_valid_reg |-> !cur_reg.last)
        else $error("first of a triangle pair marked last");

    // a stall freezes the decode stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(s0_side_reg))
        else $error("decode stage moved during a stall");

    // triangle results carry no normal and no position
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.corner_b != '0) |-> (rsp.normal_x == '0 && rsp.pos_z == '0))
        else $error("triangle result with vertex data");

    // vertex results are single
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.corner_b == '0) |-> rsp.last)
        else $error("vertex result not marked last");

endmodule

// ===== tb/uv_sphere_mesh_generator_test.sv =====
// testbench of the uv sphere mesh generator: scoreboard with vertex and triangle predictor
module uv_sphere_mesh_generator_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    // expected mesh results and the register copy they are computed from
    class mesh_scoreboard;
        logic [22:0]   radius;
        logic [8:0]    sectors;
        logic [8:0]    stacks;
        longint        cen_x;
        longint        cen_y;
        longint        cen_z;
        uvs_pkg::rsp_t mesh_q[$];
        int            errors;

        function new();
            radius  = uvs_pkg::RADIUS_RST;
            sectors = uvs_pkg::SECTORS_RST;
            stacks  = uvs_pkg::STACKS_RST;
            cen_x   = 0;
            cen_y   = 0;
            cen_z   = 0;
            errors  = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] data);
            case (idx)
                uvs_pkg::CFG_RADIUS:   radius = data[22:0];
                uvs_pkg::CFG_SECTORS:  sectors = data[8:0];
                uvs_pkg::CFG_STACKS:   stacks = data[8:0];
                uvs_pkg::CFG_CENTER_X: cen_x = longint'($signed(data));
                uvs_pkg::CFG_CENTER_Y: cen_y = longint'($signed(data));
                uvs_pkg::CFG_CENTER_Z: cen_z = longint'($signed(data));
                default: ;
            endcase
        endfunction

        function longint round_sh(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint limit(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // rotation on the residual angle, then exact quadrant fix-up
        function void angle_cos_sin(logic [31:0] phase, output longint c, output longint s);
            logic [31:0]     p2;
            uvs_pkg::quad_t  q;
            longint          x;
            longint          y;
            longint          z;
            longint          dx;
            longint          dy;
            p2 = phase + 32'h2000_0000;
            q  = uvs_pkg::quad_t'(p2[31:30]);
            z  = longint'(p2[29:0]) - 64'sh2000_0000;
            x  = longint'(uvs_pkg::GAIN_Q30);
            y  = 0;
            for (int k = 0; k < uvs_pkg::CORDIC_STEPS && k < uvs_pkg::ATAN_COUNT; k++)
            begin
                dx = y >>> k;
                dy = x >>> k;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(uvs_pkg::ATAN_TURNS[k]);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(uvs_pkg::ATAN_TURNS[k]);
                end
            end
            case (q)
                uvs_pkg::QUAD_0: begin c = x;  s = y;  end
                uvs_pkg::QUAD_1: begin c = -y; s = x;  end
                uvs_pkg::QUAD_2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void note_request(uvs_pkg::req_t r);
            uvs_pkg::rsp_t      res;
            longint unsigned    i;
            longint unsigned    j;
            longint unsigned    st;
            longint unsigned    se;
            longint unsigned    k1;
            longint unsigned    k2;
            logic [31:0]        pu;
            logic [31:0]        pv;
            longint             cu;
            longint             su;
            longint             cv;
            longint             sv;
            longint             xy;
            longint             z;
            bit                 first_tri;
            i  = r.stack_index;
            j  = r.sector_index;
            st = stacks;
            se = sectors;
            // bad counts silence every request
            if (st == 0 || se == 0 || st > uvs_pkg::MAX_STACKS || se > uvs_pkg::MAX_SECTORS)
            begin
                return;
            end
            res = '0;
            if (r.kind == uvs_pkg::KIND_VERTEX)
            begin
                if (i > st || j > se)
                begin
                    return;
                end
                pu = 32'(64'h4000_0000 - ((i << 31) / st));
                pv = 32'((j << 32) / se);
                angle_cos_sin(pu, cu, su);
                angle_cos_sin(pv, cv, sv);
                xy = round_sh(longint'(radius) * cu, 30);
                z  = round_sh(longint'(radius) * su, 30);
                res.pos_x    = 24'(limit(round_sh(xy * cv, 30) + cen_x, -8388608, 8388607));
                res.pos_y    = 24'(limit(round_sh(xy * sv, 30) + cen_y, -8388608, 8388607));
                res.pos_z    = 24'(limit(z + cen_z, -8388608, 8388607));
                res.normal_x = 16'(limit(round_sh(cu * cv, 46), -16384, 16384));
                res.normal_y = 16'(limit(round_sh(cu * sv, 46), -16384, 16384));
                res.normal_z = 16'(limit(round_sh(su, 16), -16384, 16384));
                res.last     = 1'b1;
                mesh_q = {mesh_q, res};
            end
            else
            begin
                if (i >= st || j >= se)
                begin
                    return;
                end
                k1 = i * (se + 1) + j;
                k2 = k1 + se + 1;
                first_tri = (i != 0);
                // upper triangle unless on the first stack
                if (first_tri)
                begin
                    res.corner_a = 17'(k1);
                    res.corner_b = 17'(k2);
                    res.corner_c = 17'(k1 + 1);
                    res.last     = (i == st - 1);
                    mesh_q = {mesh_q, res};
                end
                // lower triangle unless on the last stack
                if (i != st - 1)
                begin
                    res.corner_a = 17'(k1 + 1);
                    res.corner_b = 17'(k2);
                    res.corner_c = 17'(k2 + 1);
                    res.last     = 1'b1;
                    mesh_q = {mesh_q, res};
                end
            end
        endfunction

        function void cmp(string name, longint exp_v, longint act_v);
            if (exp_v != act_v)
            begin
                $error("%s expected %0d actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(uvs_pkg::rsp_t a);
            uvs_pkg::rsp_t e;
            if (mesh_q.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = mesh_q.pop_front();
            cmp("pos_x", e.pos_x, a.pos_x);
            cmp("pos_y", e.pos_y, a.pos_y);
            cmp("pos_z", e.pos_z, a.pos_z);
            cmp("normal_x", e.normal_x, a.normal_x);
            cmp("normal_y", e.normal_y, a.normal_y);
            cmp("normal_z", e.normal_z, a.normal_z);
            cmp("corner_a", e.corner_a, a.corner_a);
            cmp("corner_b", e.corner_b, a.corner_b);
            cmp("corner_c", e.corner_c, a.corner_c);
            cmp("last", e.last, a.last);
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    uvs_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready;
    uvs_pkg::rsp_t rsp;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [23:0]   cfg_data;

    mesh_scoreboard sb;
    int  cycles;
    bit  hold_off;
    int  burst_left;

    uv_sphere_mesh_generator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver: stall pattern changes now and then, plus one long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int held;
        mode      = 0;
        mode_left = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                sb.check_result(rsp);
            end
            if (hold_off)
            begin
                rsp_ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                begin
                    @(posedge clk);
                end
                hold_off = 1'b0;
                continue;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ($urandom_range(0, 1) == 1);
                default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // one request transaction, with burst gaps in front
    task automatic send_req(uvs_pkg::req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= r;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        sb.note_request(r);
    endtask

    task automatic send_one(logic kind, int i, int j);
        uvs_pkg::req_t r;
        r.kind         = kind;
        r.stack_index  = 9'(i);
        r.sector_index = 9'(j);
        send_req(r);
    endtask

    // wait for the block to drain, then write one register
    task automatic write_cfg(logic [2:0] idx, logic [23:0] data);
        req_valid <= 1'b0;
        while (sb.mesh_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mesh(logic [22:0] rad, int se, int st, int cx, int cy, int cz);
        write_cfg(uvs_pkg::CFG_RADIUS, {1'b0, rad});
        write_cfg(uvs_pkg::CFG_SECTORS, 24'(se));
        write_cfg(uvs_pkg::CFG_STACKS, 24'(st));
        write_cfg(uvs_pkg::CFG_CENTER_X, 24'(cx));
        write_cfg(uvs_pkg::CFG_CENTER_Y, 24'(cy));
        write_cfg(uvs_pkg::CFG_CENTER_Z, 24'(cz));
    endtask

    // mostly in-range grid points, some anywhere in the field range
    task automatic send_random(int count);
        int  st;
        int  se;
        logic kind;
        for (int n = 0; n < count; n++)
        begin
            st   = sb.stacks;
            se   = sb.sectors;
            kind = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 8)
            begin
                send_one(kind, $urandom_range(0, kind ? st - 1 : st),
                         $urandom_range(0, kind ? se - 1 : se));
            end
            else
            begin
                send_one(kind, $urandom_range(0, 511), $urandom_range(0, 511));
            end
        end
    endtask

    function automatic int rand_count();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 24);
    endfunction

    // stimulus
    initial
    begin
        sb         = new();
        hold_off   = 1'b0;
        burst_left = 0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= uvs_pkg::CFG_RADIUS;
        cfg_data  <= '0;
        @(posedge rst_n);
        @(posedge clk);

        // poles, seams, out-of-range and first and last stack cells at reset values
        send_one(uvs_pkg::KIND_VERTEX, 0, 0);
        send_one(uvs_pkg::KIND_VERTEX, 18, 36);
        send_one(uvs_pkg::KIND_VERTEX, 9, 18);
        send_one(uvs_pkg::KIND_VERTEX, 9, 9);
        send_one(uvs_pkg::KIND_VERTEX, 19, 0);
        send_one(uvs_pkg::KIND_VERTEX, 0, 37);
        send_one(uvs_pkg::KIND_VERTEX, 256, 256);
        send_one(uvs_pkg::KIND_VERTEX, 511, 511);
        send_one(uvs_pkg::KIND_TRIANGLE, 0, 0);
        send_one(uvs_pkg::KIND_TRIANGLE, 17, 35);
        send_one(uvs_pkg::KIND_TRIANGLE, 5, 5);
        send_one(uvs_pkg::KIND_TRIANGLE, 18, 0);
        send_one(uvs_pkg::KIND_TRIANGLE, 0, 36);
        send_random(280);

        // largest radius and grid, centers at the extremes for saturation
        set_mesh(23'h7FFFFF, 256, 256, 8388607, -8388608, 8388607);
        send_one(uvs_pkg::KIND_VERTEX, 0, 0);
        send_one(uvs_pkg::KIND_VERTEX, 256, 256);
        send_one(uvs_pkg::KIND_VERTEX, 128, 64);
        send_one(uvs_pkg::KIND_TRIANGLE, 255, 255);
        send_one(uvs_pkg::KIND_TRIANGLE, 0, 255);
        send_random(280);

        // zero radius and a single stack and sector
        set_mesh(23'd0, 1, 1, -8388608, 8388607, -8388608);
        send_one(uvs_pkg::KIND_VERTEX, 1, 1);
        send_one(uvs_pkg::KIND_VERTEX, 0, 0);
        send_one(uvs_pkg::KIND_TRIANGLE, 0, 0);
        send_random(120);

        // bad counts: everything is dropped
        set_mesh(23'd4096, 5, 0, 0, 0, 0);
        send_one(uvs_pkg::KIND_VERTEX, 0, 0);
        send_one(uvs_pkg::KIND_TRIANGLE, 0, 0);
        write_cfg(uvs_pkg::CFG_STACKS, 24'd5);
        write_cfg(uvs_pkg::CFG_SECTORS, 24'd300);
        send_one(uvs_pkg::KIND_VERTEX, 1, 1);
        send_one(uvs_pkg::KIND_TRIANGLE, 1, 1);
        write_cfg(uvs_pkg::CFG_SECTORS, 24'd0);
        send_one(uvs_pkg::KIND_VERTEX, 1, 0);
        write_cfg(uvs_pkg::CFG_SECTORS, 24'd257);
        write_cfg(uvs_pkg::CFG_STACKS, 24'd511);
        send_one(uvs_pkg::KIND_TRIANGLE, 0, 0);

        // random meshes, the first one with a long result hold-off
        for (int p = 0; p < 5; p++)
        begin
            set_mesh(($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 65536)),
                     rand_count(), rand_count(),
                     $signed(24'($urandom)), $signed(24'($urandom)), $signed(24'($urandom)));
            if (p == 0)
            begin
                hold_off = 1'b1;
            end
            send_random(230);
        end

        // drain and finish
        req_valid <= 1'b0;
        while (sb.mesh_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
